// File: design/mme_pkg.sv
// Shared types and constants of the matrix multiply engine.
// No dependencies; every other design file imports this package.
`default_nettype none

package mme_pkg;

	localparam int MaxRows  = 8;
	localparam int MaxInner = 16;
	localparam int MaxCols  = 8;
	localparam int StoreDepth = 128;
	localparam int AddrW    = $clog2(StoreDepth);
	localparam int ElemW    = 16;
	localparam int ProdW    = 2 * ElemW;
	localparam int AccW     = 36;

	typedef logic [1:0] cfg_idx_t;
	localparam cfg_idx_t CFG_ROWS  = 2'd0;
	localparam cfg_idx_t CFG_INNER = 2'd1;
	localparam cfg_idx_t CFG_COLS  = 2'd2;

	localparam logic MODE_A = 1'b0;
	localparam logic MODE_B = 1'b1;

	localparam logic [3:0] ROWS_RESET  = 4'd5;
	localparam logic [4:0] INNER_RESET = 5'd8;
	localparam logic [3:0] COLS_RESET  = 4'd3;

	// one issued product of the running dot product
	typedef struct packed {
		logic valid;
		logic first;
		logic last;
	} mac_ctl_t;

	typedef struct packed {
		logic done;
	} mac_stat_t;

	// zero counts as one, anything above the maximum as the maximum
	function automatic logic [3:0] clamp4(input logic [3:0] v, input logic [3:0] maxv);
		logic [3:0] r;
		r = v;
		if (v == 4'd0) r = 4'd1;
		else if (v > maxv) r = maxv;
		return r;
	endfunction

	function automatic logic [4:0] clamp5(input logic [4:0] v, input logic [4:0] maxv);
		logic [4:0] r;
		r = v;
		if (v == 5'd0) r = 5'd1;
		else if (v > maxv) r = maxv;
		return r;
	endfunction

endpackage

`default_nettype wire

// File: design/mme_ram.sv
// Element store: 128 x 16 single-port-write, single-read memory, read data registered.
// Depends on mme_pkg for depth and widths.
`default_nettype none

module mme_ram (
	input  wire logic                       clk,
	input  wire logic                       wr_en,
	input  wire logic [mme_pkg::AddrW-1:0]  wr_addr,
	input  wire logic signed [mme_pkg::ElemW-1:0] wr_data,
	input  wire logic [mme_pkg::AddrW-1:0]  rd_addr,
	output logic signed [mme_pkg::ElemW-1:0] rd_data
);
	import mme_pkg::*;

	logic signed [ElemW-1:0] mem_q [StoreDepth];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		rd_data <= mem_q[rd_addr];
	end

endmodule

`default_nettype wire

// File: design/mme_mac.sv
// Shared multiply-accumulate unit: register, multiply, accumulate over one dot product.
// Depends on mme_pkg; operands come from the two mme_ram read ports.
`default_nettype none

module mme_mac (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire mme_pkg::mac_ctl_t                 ctl,
	input  wire logic signed [mme_pkg::ElemW-1:0]  a_data,
	input  wire logic signed [mme_pkg::ElemW-1:0]  b_data,
	output logic signed [mme_pkg::AccW-1:0]        acc,
	output mme_pkg::mac_stat_t                     stat
);
	import mme_pkg::*;

	mac_ctl_t               ctl_s1;
	mac_ctl_t               ctl_s2;
	logic signed [ProdW-1:0] prod_s2;
	logic signed [AccW-1:0] acc_q;
	logic                   done_q;
	logic signed [AccW-1:0] prod_ext;

	assign prod_ext = {{(AccW-ProdW){prod_s2[ProdW-1]}}, prod_s2};

	// ctl_s1 lines up with the registered RAM read data
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s1 <= '0;
			ctl_s2 <= '0;
			done_q <= 1'b0;
		end else begin
			ctl_s1 <= ctl;
			ctl_s2 <= ctl_s1;
			done_q <= ctl_s2.valid & ctl_s2.last;
		end
	end

	always_ff @(posedge clk) begin
		prod_s2 <= a_data * b_data;
		if (ctl_s2.valid) begin
			acc_q <= ctl_s2.first ? prod_ext : acc_q + prod_ext;
		end
	end

	assign acc       = acc_q;
	assign stat.done = done_q;

endmodule

`default_nettype wire

// File: design/matrix_multiply_engine_unit.sv
// Matrix multiply engine: loads A and B element by element, then streams C = A x B.
// Uses mme_pkg, mme_ram (A and B stores) and mme_mac (shared multiply-accumulate).
//
// Input channel (in_valid / in_stall): one element per transfer, mode 0 for A,
// mode 1 for B, both row-major. in_stall is low while the block is idle.
// Extra A elements beyond rows*inner are dropped. The B transfer that
// completes inner*cols elements, or any B transfer once B is full, starts
// the multiply; in_stall stays high until C's last entry is in the output register.
// Output channel (out_valid / out_stall): entries of C in row-major order with
// row, column and a flag on the last entry. The output register holds its
// entry while out_stall is high; the sequencer waits for it.
// Each entry issues its inner products through the one shared multiplier, then
// passes two pipeline stages, one accumulate and one handoff to the output
// register; the next entry issues only after that handoff, which waits on any
// output stall.
// Configuration (cfg_valid / cfg_ready, cfg_index, cfg_data) is always ready
// and must be written while idle. Reset clears the load counters and sequencer
// state and sets the sizes to 5 x 8 x 3; the element stores are not cleared.
`default_nettype none

module matrix_multiply_engine_unit (
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  wire logic                    cfg_valid,
	output logic                         cfg_ready,
	input  wire mme_pkg::cfg_idx_t       cfg_index,
	input  wire logic [4:0]              cfg_data,
	input  wire logic                    in_valid,
	output logic                         in_stall,
	input  wire logic                    mode,
	input  wire logic signed [15:0]      element,
	output logic                         out_valid,
	input  wire logic                    out_stall,
	output logic signed [35:0]           product_entry,
	output logic [2:0]                   out_row,
	output logic [2:0]                   out_col,
	output logic                         final_entry
);
	import mme_pkg::*;

	typedef enum logic [3:0] {
		S_IDLE  = 4'b0001,
		S_ISSUE = 4'b0010,
		S_WAIT  = 4'b0100,
		S_HOLD  = 4'b1000
	} state_t;

	state_t       state_q;
	logic [3:0]   rows_q;
	logic [4:0]   inner_q;
	logic [3:0]   cols_q;
	logic [3:0]   rows_c;
	logic [4:0]   inner_c;
	logic [3:0]   cols_c;
	logic [7:0]   a_size;
	logic [7:0]   b_size;
	logic [7:0]   a_count_q;
	logic [7:0]   b_count_q;
	logic [8:0]   b_count_inc;
	logic         in_xfer;
	logic         a_wr;
	logic         b_wr;
	logic         start;

	logic [2:0]       i_q;
	logic [2:0]       j_q;
	logic [3:0]       k_q;
	logic [AddrW-1:0] a_base_q;
	logic [AddrW-1:0] a_addr_q;
	logic [AddrW-1:0] b_addr_q;
	logic [AddrW:0]   a_base_nxt;
	logic [AddrW:0]   b_addr_step;
	logic [3:0]       k_last;
	logic [2:0]       row_last;
	logic [2:0]       col_last;
	logic             last_row;
	logic             last_col;
	logic             out_free;
	logic             out_load;

	mac_ctl_t                mac_ctl;
	mac_stat_t               mac_stat;
	logic signed [ElemW-1:0] a_rd;
	logic signed [ElemW-1:0] b_rd;
	logic signed [AccW-1:0]  acc;

	// configuration
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rows_q  <= ROWS_RESET;
			inner_q <= INNER_RESET;
			cols_q  <= COLS_RESET;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				CFG_ROWS:  rows_q  <= cfg_data[3:0];
				CFG_INNER: inner_q <= cfg_data;
				CFG_COLS:  cols_q  <= cfg_data[3:0];
				default: ;
			endcase
		end
	end

	assign rows_c  = clamp4(rows_q, 4'(MaxRows));
	assign inner_c = clamp5(inner_q, 5'(MaxInner));
	assign cols_c  = clamp4(cols_q, 4'(MaxCols));
	assign a_size  = {4'b0, rows_c} * {3'b0, inner_c};
	assign b_size  = {3'b0, inner_c} * {4'b0, cols_c};

	// loading
	assign in_stall    = (state_q != S_IDLE);
	assign in_xfer     = in_valid && !in_stall;
	assign a_wr        = in_xfer && (mode == MODE_A) && (a_count_q < a_size);
	assign b_wr        = in_xfer && (mode == MODE_B) && (b_count_q < b_size);
	assign b_count_inc = {1'b0, b_count_q} + 9'd1;
	// the element that fills B, or any B element once B is already full
	assign start       = in_xfer && (mode == MODE_B) && (b_count_inc >= {1'b0, b_size});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			a_count_q <= '0;
			b_count_q <= '0;
		end else if (start) begin
			a_count_q <= '0;
			b_count_q <= '0;
		end else begin
			if (a_wr) a_count_q <= a_count_q + 8'd1;
			if (b_wr) b_count_q <= b_count_q + 8'd1;
		end
	end

	// sequencer
	assign k_last      = 4'(inner_c - 5'd1);
	assign row_last    = 3'(rows_c - 4'd1);
	assign col_last    = 3'(cols_c - 4'd1);
	assign last_row    = (i_q == row_last);
	assign last_col    = (j_q == col_last);
	assign a_base_nxt  = {1'b0, a_base_q} + {{(AddrW-4){1'b0}}, inner_c};
	assign b_addr_step = {1'b0, b_addr_q} + {{(AddrW-3){1'b0}}, cols_c};
	assign out_free    = !out_valid || !out_stall;
	assign out_load    = (state_q == S_HOLD) && out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			unique case (state_q)
				S_IDLE:  if (start) state_q <= S_ISSUE;
				S_ISSUE: if (k_q == k_last) state_q <= S_WAIT;
				S_WAIT:  if (mac_stat.done) state_q <= S_HOLD;
				S_HOLD: begin
					if (out_load) state_q <= (last_row && last_col) ? S_IDLE : S_ISSUE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			i_q      <= '0;
			j_q      <= '0;
			k_q      <= '0;
			a_base_q <= '0;
			a_addr_q <= '0;
			b_addr_q <= '0;
		end else if (state_q == S_ISSUE) begin
			k_q      <= k_q + 4'd1;
			a_addr_q <= a_addr_q + AddrW'(1);
			b_addr_q <= b_addr_step[AddrW-1:0];
		end else if (out_load) begin
			k_q <= '0;
			if (last_col) begin
				// advance to the next row of A
				i_q      <= i_q + 3'd1;
				j_q      <= '0;
				a_base_q <= a_base_nxt[AddrW-1:0];
				a_addr_q <= a_base_nxt[AddrW-1:0];
				b_addr_q <= '0;
			end else begin
				j_q      <= j_q + 3'd1;
				a_addr_q <= a_base_q;
				b_addr_q <= AddrW'({1'b0, j_q} + 4'd1);
			end
		end
	end

	assign mac_ctl.valid = (state_q == S_ISSUE);
	assign mac_ctl.first = (k_q == 4'd0);
	assign mac_ctl.last  = (k_q == k_last);

	mme_ram u_a_store (
		.clk     (clk),
		.wr_en   (a_wr),
		.wr_addr (a_count_q[AddrW-1:0]),
		.wr_data (element),
		.rd_addr (a_addr_q),
		.rd_data (a_rd)
	);

	mme_ram u_b_store (
		.clk     (clk),
		.wr_en   (b_wr),
		.wr_addr (b_count_q[AddrW-1:0]),
		.wr_data (element),
		.rd_addr (b_addr_q),
		.rd_data (b_rd)
	);

	mme_mac u_mac (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (mac_ctl),
		.a_data (a_rd),
		.b_data (b_rd),
		.acc    (acc),
		.stat   (mac_stat)
	);

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (out_load) begin
			out_valid <= 1'b1;
		end else if (!out_stall) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			product_entry <= acc;
			out_row       <= i_q;
			out_col       <= j_q;
			final_entry   <= last_row && last_col;
		end
	end

	a_done_in_wait: assert property (@(posedge clk) disable iff (!arst_n)
		mac_stat.done |-> state_q == S_WAIT)
		else $error("accumulator finished outside the wait state");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		a_count_q <= 8'(StoreDepth) && b_count_q <= 8'(StoreDepth))
		else $error("load count ran past the store depth");

	a_final_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(out_load && last_row && last_col) |=> state_q == S_IDLE)
		else $error("sequencer kept running after the last entry");

	a_issue_range: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_ISSUE |-> k_q <= k_last && i_q <= row_last && j_q <= col_last)
		else $error("issue index outside the matrix");

	a_start_idle: assert property (@(posedge clk) disable iff (!arst_n)
		start |=> state_q == S_ISSUE && a_count_q == 8'd0 && b_count_q == 8'd0)
		else $error("multiply did not start cleanly");

endmodule

`default_nettype wire

// File: dv/matrix_multiply_engine_unit_tb.sv
// Self-checking testbench for matrix_multiply_engine_unit: loads A and B, checks every C entry.
// Depends on mme_pkg and the RTL only; a built-in predictor tracks the stores and sizes.
`timescale 1ns / 1ps

module matrix_multiply_engine_unit_tb;
	import mme_pkg::*;

	localparam cfg_idx_t CFG_UNUSED = 2'd3;
	localparam int SETTLE_CYCLES = MaxInner + 8;
	localparam int HOLD_CYCLES = 200;
	localparam int RANDOM_ITEMS = 20;
	localparam int LIMIT_NS = 5_000_000;

	typedef struct {
		logic signed [35:0] value;
		logic [2:0] row;
		logic [2:0] col;
		logic fin;
	} c_entry_t;

	logic clk;
	logic arst_n;
	logic cfg_valid;
	logic cfg_ready;
	cfg_idx_t cfg_index;
	logic [4:0] cfg_data;
	logic in_valid;
	logic in_stall;
	logic mode;
	logic signed [15:0] element;
	logic out_valid;
	logic out_stall;
	logic signed [35:0] product_entry;
	logic [2:0] out_row;
	logic [2:0] out_col;
	logic final_entry;

	// predictor state
	logic [3:0] rows_reg;
	logic [4:0] inner_reg;
	logic [3:0] cols_reg;
	logic signed [15:0] a_mem [StoreDepth];
	logic signed [15:0] b_mem [StoreDepth];
	int a_cnt;
	int b_cnt;
	c_entry_t pending_entries[$];

	int mismatch_count = 0;
	int elements_sent = 0;
	int ignored_items = 0;
	int products_formed = 0;
	int entries_checked = 0;
	int reg_writes = 0;
	int idle_pct = 30;
	bit quiet = 0;
	bit hold_req = 0;
	int stall_left = 0;

	matrix_multiply_engine_unit dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.mode(mode),
		.element(element),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.product_entry(product_entry),
		.out_row(out_row),
		.out_col(out_col),
		.final_entry(final_entry)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#(LIMIT_NS);
		$display("[matrix_multiply_engine_unit] ERROR");
		$finish;
	end

	function automatic int dim_used(input int v, input int maxv);
		if (v == 0) return 1;
		if (v > maxv) return maxv;
		return v;
	endfunction

	function automatic void log_mismatch(input string msg);
		mismatch_count++;
		if (mismatch_count <= 10) $display("mismatch: %s", msg);
	endfunction

	// update the stores for one accepted element and queue any C entries it releases
	function automatic void predict_element(input logic m, input logic signed [15:0] e);
		int rows;
		int inner;
		int cols;
		longint acc;
		c_entry_t ent;
		rows = dim_used(int'(rows_reg), MaxRows);
		inner = dim_used(int'(inner_reg), MaxInner);
		cols = dim_used(int'(cols_reg), MaxCols);
		elements_sent++;
		if (m == MODE_A) begin
			if (a_cnt < rows * inner) begin
				a_mem[a_cnt] = e;
				a_cnt++;
			end else begin
				ignored_items++;
			end
			return;
		end
		if (b_cnt < inner * cols) begin
			b_mem[b_cnt] = e;
			b_cnt++;
		end
		if (b_cnt < inner * cols) return;
		for (int i = 0; i < rows; i++) begin
			for (int j = 0; j < cols; j++) begin
				acc = 0;
				for (int k = 0; k < inner; k++)
					acc += longint'(a_mem[i * inner + k]) * longint'(b_mem[k * cols + j]);
				ent.value = acc[35:0];
				ent.row = 3'(i);
				ent.col = 3'(j);
				ent.fin = (i == rows - 1 && j == cols - 1);
				pending_entries.push_back(ent);
			end
		end
		products_formed++;
		a_cnt = 0;
		b_cnt = 0;
	endfunction

	function automatic logic signed [15:0] rand_element();
		case ($urandom_range(7))
			0: return -16'sd32768;
			1: return 16'sd32767;
			2: return 16'sd0;
			default: return 16'($urandom);
		endcase
	endfunction

	// result side: random stall bursts, plus one long hold-off on request
	initial begin
		out_stall = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_req) begin
				hold_req = 0;
				out_stall <= 1'b1;
				repeat (HOLD_CYCLES) @(negedge clk);
				out_stall <= 1'b0;
			end else if (stall_left > 0) begin
				out_stall <= 1'b1;
				stall_left--;
			end else if (!quiet && idle_pct != 0 && $urandom_range(99) < idle_pct) begin
				out_stall <= 1'b1;
				stall_left = $urandom_range(0, 8);
			end else begin
				out_stall <= 1'b0;
			end
		end
	end

	always @(posedge clk) begin : check_entry
		c_entry_t want;
		if (arst_n && out_valid && !out_stall) begin
			entries_checked++;
			if (pending_entries.size() == 0) begin
				log_mismatch($sformatf("unexpected entry %0d at (%0d,%0d) last=%0b",
					product_entry, out_row, out_col, final_entry));
			end else begin
				want = pending_entries.pop_front();
				if (product_entry !== want.value || out_row !== want.row ||
					out_col !== want.col || final_entry !== want.fin)
					log_mismatch($sformatf(
						"expected %0d (%0d,%0d) last=%0b, got %0d (%0d,%0d) last=%0b",
						want.value, want.row, want.col, want.fin,
						product_entry, out_row, out_col, final_entry));
			end
		end
	end

	// all tasks below start and end on a falling edge
	task automatic send_element(input logic m, input logic signed [15:0] e);
		if (!quiet && idle_pct != 0 && $urandom_range(99) < idle_pct) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 9)) @(negedge clk);
		end
		in_valid <= 1'b1;
		mode <= m;
		element <= e;
		do @(posedge clk); while (in_stall);
		predict_element(m, e);
		@(negedge clk);
	endtask

	task automatic drop_input();
		in_valid <= 1'b0;
		@(negedge clk);
	endtask

	// wait out every pending entry, then give in-flight loads time to land
	task automatic settle();
		while (pending_entries.size() != 0) @(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic write_reg(input cfg_idx_t idx, input logic [4:0] value);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		do @(posedge clk); while (!cfg_ready);
		case (idx)
			CFG_ROWS: rows_reg = value[3:0];
			CFG_INNER: inner_reg = value;
			CFG_COLS: cols_reg = value[3:0];
			default: ;
		endcase
		reg_writes++;
		@(negedge clk);
		cfg_valid <= 1'b0;
		@(negedge clk);
	endtask

	task automatic set_dims(input int r, input int i, input int c);
		write_reg(CFG_ROWS, 5'(r));
		write_reg(CFG_INNER, 5'(i));
		write_reg(CFG_COLS, 5'(c));
	endtask

	// one well-formed load of A then B at the current sizes, random content
	task automatic send_full_set();
		int a_need;
		int b_need;
		a_need = dim_used(int'(rows_reg), MaxRows) * dim_used(int'(inner_reg), MaxInner);
		b_need = dim_used(int'(inner_reg), MaxInner) * dim_used(int'(cols_reg), MaxCols);
		for (int n = 0; n < a_need; n++) send_element(MODE_A, rand_element());
		for (int n = 0; n < b_need; n++) send_element(MODE_B, rand_element());
	endtask

	task automatic test_reset_dims();
		send_full_set();
		drop_input();
	endtask

	task automatic test_element_extremes();
		logic signed [15:0] a_vals [6] = '{-16'sd32768, -16'sd32768, 16'sd32767,
			16'sd32767, 16'sd0, -16'sd1};
		logic signed [15:0] b_vals [6] = '{-16'sd32768, 16'sd32767, 16'sd32767,
			-16'sd32768, -16'sd32768, 16'sd1};
		settle();
		set_dims(1, 1, 1);
		for (int n = 0; n < 6; n++) begin
			send_element(MODE_A, a_vals[n]);
			send_element(MODE_B, b_vals[n]);
		end
		drop_input();
	endtask

	task automatic test_zero_dims();
		settle();
		set_dims(0, 0, 0);
		send_element(MODE_A, -16'sd256);
		send_element(MODE_B, 16'sd384);
		drop_input();
	endtask

	// over-range values clamp to 8 x 16 x 8; this also writes every store entry
	task automatic test_full_size();
		settle();
		set_dims(15, 31, 9);
		send_full_set();
		drop_input();
	endtask

	// column 0 reaches the largest sum, column 1 the most negative
	task automatic test_peak_sum();
		settle();
		set_dims(1, 16, 2);
		for (int n = 0; n < 16; n++) send_element(MODE_A, -16'sd32768);
		for (int n = 0; n < 16; n++) begin
			send_element(MODE_B, -16'sd32768);
			send_element(MODE_B, 16'sd32767);
		end
		drop_input();
	endtask

	task automatic test_excess_a();
		settle();
		set_dims(2, 2, 2);
		for (int n = 0; n < 7; n++) send_element(MODE_A, rand_element());
		for (int n = 0; n < 4; n++) send_element(MODE_B, rand_element());
		drop_input();
	endtask

	// shrink the sizes below the B count already loaded; the next B fires at once
	task automatic test_shrunk_b();
		settle();
		set_dims(2, 3, 3);
		for (int n = 0; n < 6; n++) send_element(MODE_A, rand_element());
		for (int n = 0; n < 5; n++) send_element(MODE_B, rand_element());
		drop_input();
		settle();
		write_reg(CFG_INNER, 5'd1);
		write_reg(CFG_COLS, 5'd2);
		send_element(MODE_B, rand_element());
		drop_input();
	endtask

	// reload only part of A; the rest keeps its older values
	task automatic test_stale_a();
		settle();
		set_dims(2, 2, 2);
		for (int n = 0; n < 2; n++) send_element(MODE_A, rand_element());
		for (int n = 0; n < 4; n++) send_element(MODE_B, rand_element());
		drop_input();
	endtask

	task automatic test_config_masking();
		settle();
		write_reg(CFG_UNUSED, 5'd31);
		write_reg(CFG_ROWS, 5'd20);
		write_reg(CFG_INNER, 5'd2);
		write_reg(CFG_COLS, 5'd1);
		send_full_set();
		drop_input();
	endtask

	// hold the result side long enough that the second load backs up on in_stall
	task automatic test_output_backpressure();
		settle();
		set_dims(2, 2, 2);
		hold_req = 1;
		send_full_set();
		send_full_set();
		drop_input();
	endtask

	task automatic test_random_mix();
		int done;
		int start;
		int r;
		int i;
		int c;
		int n;
		done = 0;
		while (done < RANDOM_ITEMS) begin
			settle();
			quiet = (done >= RANDOM_ITEMS / 2);
			case ($urandom_range(2))
				0: idle_pct = 0;
				1: idle_pct = 15;
				default: idle_pct = 40;
			endcase
			if ($urandom_range(9) == 0) begin
				r = $urandom_range(0, 15);
				i = $urandom_range(0, 31);
				c = $urandom_range(0, 15);
			end else begin
				r = $urandom_range(1, 4);
				i = $urandom_range(1, 6);
				c = $urandom_range(1, 4);
			end
			set_dims(r, i, c);
			start = elements_sent - ignored_items;
			if ($urandom_range(4) != 0) begin
				send_full_set();
			end else begin
				n = $urandom_range(1, dim_used(r, MaxRows) * dim_used(i, MaxInner) +
					dim_used(i, MaxInner) * dim_used(c, MaxCols) + 4);
				repeat (n) send_element(1'($urandom_range(1)), rand_element());
			end
			drop_input();
			done += elements_sent - ignored_items - start;
		end
	endtask

	initial begin
		arst_n = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = CFG_ROWS;
		cfg_data = 5'd0;
		in_valid = 1'b0;
		mode = MODE_A;
		element = 16'sd0;
		rows_reg = ROWS_RESET;
		inner_reg = INNER_RESET;
		cols_reg = COLS_RESET;
		a_cnt = 0;
		b_cnt = 0;
		repeat (10) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		test_reset_dims();
		test_element_extremes();
		test_zero_dims();
		test_full_size();
		test_peak_sum();
		test_excess_a();
		test_shrunk_b();
		test_stale_a();
		test_config_masking();
		test_output_backpressure();
		test_random_mix();

		while (pending_entries.size() != 0) @(negedge clk);
		repeat (MaxInner + 24) @(negedge clk);

		$display("covered %0d elements (%0d dropped as extra A), %0d products, %0d entries",
			elements_sent, ignored_items, products_formed, entries_checked);
		$display("%0d register writes, %0d mismatches", reg_writes, mismatch_count);
		if (mismatch_count == 0)
			$display("[matrix_multiply_engine_unit] OK");
		else
			$display("[matrix_multiply_engine_unit] ERROR");
		$finish;
	end

endmodule
